FILE: hdl/vagg_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the vector arrow glyph generator.
// No dependencies; every other file in hdl/ imports this package.
package vagg_pkg;

  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned IndexWidthDef = 16;
  localparam int unsigned QDepth        = 2;
  localparam int unsigned VW            = 40;  // vertex arithmetic width

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_STRIP = 2'd2;
  localparam logic [1:0] KIND_MARK  = 2'd3;

  localparam logic [1:0] ANCHOR_CENTRE = 2'd1;
  localparam logic [1:0] ANCHOR_TIP    = 2'd2;

  localparam logic [2:0] REG_SCALE = 3'd0;
  localparam logic [2:0] REG_SHOWZ = 3'd1;
  localparam logic [2:0] REG_ANCH  = 3'd2;
  localparam logic [2:0] REG_HEAD  = 3'd3;
  localparam logic [2:0] REG_HLEN  = 3'd4;
  localparam logic [2:0] REG_HWID  = 3'd5;
  localparam logic [2:0] REG_PICK  = 3'd6;
  localparam logic [2:0] REG_ZLIM  = 3'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [31:0]        color_rgba;
    logic               has_color;
    logic [15:0]        vector_index;
    logic               final_vector;
  } item_t;

  typedef struct packed {
    logic [1:0]         prim_kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        out_color;
    logic               color_valid;
    logic               pick_valid;
    logic [15:0]        pick_index;
    logic               prim_end;
    logic               last;
    logic               batch_done;
  } result_t;

  typedef struct packed {
    logic signed [31:0] scale_factor;
    logic               show_zero;
    logic [1:0]         anchor_mode;
    logic               draw_head;
    logic [16:0]        head_length_frac;
    logic [16:0]        head_width_frac;
    logic               pick_feedback;
    logic [15:0]        zero_length_limit;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -70'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

FILE: hdl/vagg_front.sv
`timescale 1ns / 1ps
// Intake side: takes input words on start/busy and holds them in a short queue.
// Depends on vagg_pkg.
module vagg_front
  import vagg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  item_t item_i,
  output logic  busy,
  output logic  head_valid_o,
  output item_t head_o,
  input  logic  pop_i
);

  localparam int unsigned PW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CW = $clog2(QDepth + 1);

  item_t          mem_q [QDepth];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           push, pop;

  assign busy         = (cnt_q == CW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign push         = start && !busy;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(QDepth - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(QDepth - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/vagg_isqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 64-bit word, one root bit per cycle.
// Depends on vagg_pkg.
module vagg_isqrt
  import vagg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] n_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] t, trial;
  logic        ge;

  assign t      = {rem_q, n_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (t >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(t - trial) : t[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/vagg_div.sv
`timescale 1ns / 1ps
// Restoring divider for x * 2^30 / d, truncating toward zero, one bit per cycle.
// Depends on vagg_pkg; callers keep |x| <= d so the quotient fits in 31 bits.
module vagg_div
  import vagg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic [30:0]        d_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);

  logic [30:0] rem_q, nb_q, quo_q, d_q;
  logic        neg_q, busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] xa, t, dx;
  logic        ge;

  assign xa     = x_i[31] ? 32'(-x_i) : 32'(x_i);
  assign t      = {rem_q, nb_q[30]};
  assign dx     = {1'b0, d_q};
  assign ge     = (t >= dx);
  assign done_o = done_q;
  assign q_o    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= xa[31:1];
      nb_q  <= {xa[0], 30'd0};
      neg_q <= x_i[31];
      d_q   <= d_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 31'(t - dx) : t[30:0];
      nb_q  <= {nb_q[29:0], 1'b0};
      quo_q <= {quo_q[29:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/vagg_back.sv
`timescale 1ns / 1ps
// Execution side: scales the vector, sizes it, places shaft and wings, emits vertices.
// Depends on vagg_pkg, vagg_isqrt and vagg_div.
module vagg_back
  import vagg_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned INDEX_WIDTH = IndexWidthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_SCL  = 5'd1,  ST_SQ   = 5'd2,  ST_LEN  = 5'd3;
  localparam logic [4:0] ST_DEC  = 5'd4,  ST_BT   = 5'd5,  ST_SH   = 5'd6,  ST_MW   = 5'd7;
  localparam logic [4:0] ST_P1   = 5'd8,  ST_QLD  = 5'd9,  ST_QPRE = 5'd10, ST_QSQ  = 5'd11;
  localparam logic [4:0] ST_R1   = 5'd12, ST_U30  = 5'd13, ST_U31  = 5'd14, ST_WLD  = 5'd15;
  localparam logic [4:0] ST_WPRE = 5'd16, ST_WSQ  = 5'd17, ST_R2   = 5'd18, ST_WSQ2 = 5'd19;
  localparam logic [4:0] ST_L1   = 5'd20, ST_CL   = 5'd21, ST_U22  = 5'd22, ST_U2XY = 5'd23;
  localparam logic [4:0] ST_OFF  = 5'd24, ST_HEAD = 5'd25, ST_ONE  = 5'd26;

  localparam logic signed [31:0] ONE30 = 32'sh40000000;

  logic [4:0]            state_q;
  logic [2:0]            idx_q;
  item_t                 item_q;
  logic signed [31:0]    p_q [3];
  logic signed [31:0]    c_q [3];
  logic signed [31:0]    u2_q [3];
  logic signed [31:0]    u3_q [2];
  logic signed [31:0]    cl_q;
  logic [63:0]           sum_q;
  logic [31:0]           len_q, r1_q, r2_q, l1_q;
  logic [33:0]           mw_q;
  logic signed [VW-1:0]  base_q [3];
  logic signed [VW-1:0]  tip_q [3];
  logic signed [VW-1:0]  p1_q [3];
  logic signed [VW-1:0]  off_q [6];
  logic                  res_valid_q;
  result_t               res_q;

  logic signed [31:0]    pos_w [3];
  logic signed [31:0]    vec_w [3];
  logic signed [17:0]    fac;
  logic                  heads;
  logic signed [34:0]    mul_a, mul_b;
  logic signed [69:0]    prod;

  logic                  sq_start, sq_done, dv_start, dv_done;
  logic [31:0]           sq_root;
  logic signed [31:0]    dv_x, dv_q;
  logic [30:0]           dv_d;

  logic [31:0]           ab [3];
  logic [31:0]           orab;
  logic [4:0]            msb, lsh;
  logic                  pre_done, pre_right;

  logic signed [VW-1:0]  nbase [3];
  logic signed [VW-1:0]  ntip [3];
  logic                  emit;
  result_t               emit_r;
  logic signed [VW-1:0]  vtx [3];

  assign pos_w[0] = item_q.pos_x;
  assign pos_w[1] = item_q.pos_y;
  assign pos_w[2] = item_q.pos_z;
  assign vec_w[0] = item_q.vec_x;
  assign vec_w[1] = item_q.vec_y;
  assign vec_w[2] = item_q.vec_z;

  assign fac   = $signed(18'd65536) - $signed({1'b0, cfg_i.head_length_frac});
  assign heads = !cfg_i.pick_feedback && cfg_i.draw_head;
  assign prod  = mul_a * mul_b;

  assign item_pop_o     = (state_q == ST_IDLE) && item_valid_i;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  vagg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (sum_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  vagg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .x_i     (dv_x),
    .d_i     (dv_d),
    .done_o  (dv_done),
    .q_o     (dv_q)
  );

  assign sq_start = (idx_q == 3'd0) && ((state_q == ST_LEN) || (state_q == ST_R1) ||
                                        (state_q == ST_R2) || (state_q == ST_L1));
  assign dv_start = (idx_q == 3'd0) && ((state_q == ST_U30) || (state_q == ST_U31) ||
                                        (state_q == ST_CL) || (state_q == ST_U22));

  always_comb begin
    dv_x = c_q[1];
    dv_d = r1_q[30:0];
    case (state_q)
      ST_U31: dv_x = -c_q[0];
      ST_CL: begin
        dv_x = c_q[2];
        dv_d = l1_q[30:0];
      end
      ST_U22: begin
        dv_x = $signed(r2_q);
        dv_d = l1_q[30:0];
      end
      default: ;
    endcase
  end

  // prescale: bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i] = c_q[i][31] ? 32'(-c_q[i]) : 32'(c_q[i]);
    end
    orab = ab[0] | ab[1] | ab[2];
    msb  = '0;
    for (int b = 0; b < 29; b++) begin
      if (orab[b]) msb = 5'(b);
    end
    lsh       = 5'd29 - msb;
    pre_right = (orab[31:30] != 2'b00);
    pre_done  = (orab == '0) || (!pre_right && orab[29]);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SCL: begin
        mul_a = 35'(vec_w[idx_q[1:0]]);
        mul_b = 35'(cfg_i.scale_factor);
      end
      ST_SQ: begin
        mul_a = 35'(p_q[idx_q[1:0]]);
        mul_b = 35'(p_q[idx_q[1:0]]);
      end
      ST_MW: begin
        mul_a = $signed({3'b000, len_q});
        mul_b = $signed({18'd0, cfg_i.head_width_frac});
      end
      ST_P1: begin
        mul_a = 35'(p_q[idx_q[1:0]]);
        mul_b = 35'(fac);
      end
      ST_QSQ, ST_WSQ: begin
        mul_a = 35'(c_q[idx_q[1:0]]);
        mul_b = 35'(c_q[idx_q[1:0]]);
      end
      ST_WSQ2: begin
        mul_a = 35'(c_q[2]);
        mul_b = 35'(c_q[2]);
      end
      ST_U2XY: begin
        if (idx_q == 3'd0) begin
          mul_a = 35'(cl_q);
          mul_b = 35'(u3_q[1]);
        end else begin
          mul_a = -35'(cl_q);
          mul_b = 35'(u3_q[0]);
        end
      end
      ST_OFF: begin
        mul_b = $signed({1'b0, mw_q});
        case (idx_q)
          3'd0:    mul_a = 35'(u2_q[0]);
          3'd1:    mul_a = 35'(u2_q[1]);
          3'd2:    mul_a = 35'(u2_q[2]);
          3'd3:    mul_a = 35'(u3_q[0]);
          3'd4:    mul_a = 35'(u3_q[1]);
          default: mul_a = '0;
        endcase
      end
      default: ;
    endcase
  end

  // shaft placement by anchor mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg_i.anchor_mode == ANCHOR_CENTRE) begin
        ntip[i]  = VW'(pos_w[i]) + VW'(p_q[i] >>> 1);
        nbase[i] = VW'(pos_w[i]) - VW'(p_q[i] >>> 1);
      end else if (cfg_i.anchor_mode == ANCHOR_TIP) begin
        ntip[i]  = VW'(pos_w[i]);
        nbase[i] = VW'(pos_w[i]) - VW'(p_q[i]);
      end else begin
        ntip[i]  = VW'(pos_w[i]) + VW'(p_q[i]);
        nbase[i] = VW'(pos_w[i]);
      end
    end
  end

  // vertex selection for the result word, registered into res_q
  always_comb begin
    emit   = 1'b0;
    emit_r = '0;
    for (int i = 0; i < 3; i++) vtx[i] = '0;
    case (state_q)
      ST_ONE: begin
        emit = 1'b1;
        emit_r.last = 1'b1;
        if (cfg_i.show_zero) begin
          emit_r.prim_kind = KIND_POINT;
          emit_r.prim_end  = 1'b1;
          for (int i = 0; i < 3; i++) vtx[i] = VW'(pos_w[i]);
        end else begin
          emit_r.prim_kind = KIND_MARK;
        end
      end
      ST_SH: begin
        emit = 1'b1;
        emit_r.prim_kind = KIND_LINE;
        for (int i = 0; i < 3; i++) vtx[i] = (idx_q == 3'd0) ? base_q[i] : tip_q[i];
        if (idx_q != 3'd0) begin
          emit_r.prim_end = 1'b1;
          emit_r.last     = !heads;
        end else if (cfg_i.pick_feedback) begin
          emit_r.pick_valid = 1'b1;
          for (int b = 0; b < 16; b++) begin
            emit_r.pick_index[b] = item_q.vector_index[b] && (b < INDEX_WIDTH);
          end
        end
      end
      ST_HEAD: begin
        emit = 1'b1;
        emit_r.prim_kind = KIND_STRIP;
        emit_r.prim_end  = (idx_q == 3'd2) || (idx_q == 3'd5);
        emit_r.last      = (idx_q == 3'd5);
        for (int i = 0; i < 3; i++) begin
          case (idx_q)
            3'd0:    vtx[i] = p1_q[i] + off_q[i];
            3'd2:    vtx[i] = p1_q[i] - off_q[i];
            3'd3:    vtx[i] = p1_q[i] + off_q[3 + i];
            3'd5:    vtx[i] = p1_q[i] - off_q[3 + i];
            default: vtx[i] = tip_q[i];
          endcase
        end
      end
      default: ;
    endcase
    emit_r.vert_x = sat32(70'(vtx[0]));
    emit_r.vert_y = sat32(70'(vtx[1]));
    emit_r.vert_z = sat32(70'(vtx[2]));
    // colour rides on the first word of the item only
    if (item_q.has_color && ((state_q == ST_ONE) || ((state_q == ST_SH) && (idx_q == 3'd0)))) begin
      emit_r.color_valid = 1'b1;
      emit_r.out_color   = item_q.color_rgba;
    end
    emit_r.batch_done = emit_r.last && item_q.final_vector;
  end

  always_ff @(posedge clk_i) begin
    res_q <= emit_r;
    case (state_q)
      ST_IDLE: begin
        item_q <= item_i;
        sum_q  <= '0;
      end
      ST_SCL:  p_q[idx_q[1:0]] <= sat32(prod >>> FRAC_BITS);
      ST_SQ, ST_QSQ, ST_WSQ, ST_WSQ2: sum_q <= sum_q + prod[63:0];
      ST_LEN:  if (sq_done) len_q <= sq_root;
      ST_BT: begin
        base_q <= nbase;
        tip_q  <= ntip;
      end
      ST_MW:   mw_q <= prod[49:16];
      ST_P1: begin
        p1_q[idx_q[1:0]] <= base_q[idx_q[1:0]] + VW'(prod >>> 16);
        if (p_q[0] == '0 && p_q[1] == '0) begin
          u2_q[0] <= '0;
          u2_q[2] <= '0;
          u2_q[1] <= (p_q[2] > 0) ? ONE30 : ((p_q[2] < 0) ? -ONE30 : '0);
          u3_q[0] <= (p_q[2] != '0) ? -ONE30 : '0;
          u3_q[1] <= '0;
        end
      end
      ST_QLD: begin
        c_q[0] <= p_q[0];
        c_q[1] <= p_q[1];
        c_q[2] <= '0;
        sum_q  <= '0;
      end
      ST_WLD: begin
        c_q   <= p_q;
        sum_q <= '0;
      end
      ST_QPRE, ST_WPRE: begin
        if (!pre_done) begin
          for (int i = 0; i < 3; i++) begin
            c_q[i] <= pre_right ? (c_q[i] >>> 1) : (c_q[i] <<< lsh);
          end
        end
      end
      ST_R1:   if (sq_done) r1_q <= sq_root;
      ST_R2:   if (sq_done) r2_q <= sq_root;
      ST_L1:   if (sq_done) l1_q <= sq_root;
      ST_U30:  if (dv_done) u3_q[0] <= dv_q;
      ST_U31:  if (dv_done) u3_q[1] <= dv_q;
      ST_CL:   if (dv_done) cl_q <= dv_q;
      ST_U22:  if (dv_done) u2_q[2] <= dv_q;
      ST_U2XY: u2_q[idx_q[1:0]] <= 32'(prod >>> 30);
      ST_OFF:  off_q[idx_q] <= VW'(prod >>> 30);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
      unique case (state_q)
        ST_IDLE: if (item_valid_i) begin
          state_q <= ST_SCL;
          idx_q   <= '0;
        end
        ST_SCL, ST_SQ: begin
          if (idx_q == 3'd2) begin
            state_q <= (state_q == ST_SCL) ? ST_SQ : ST_LEN;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_LEN, ST_R1, ST_R2, ST_L1, ST_U30, ST_U31, ST_CL, ST_U22: begin
          if (idx_q == 3'd0) begin
            idx_q <= 3'd1;
          end else if (sq_done || dv_done) begin
            idx_q <= '0;
            case (state_q)
              ST_LEN:  state_q <= ST_DEC;
              ST_R1:   state_q <= ST_U30;
              ST_U30:  state_q <= ST_U31;
              ST_U31:  state_q <= ST_WLD;
              ST_R2:   state_q <= ST_WSQ2;
              ST_L1:   state_q <= ST_CL;
              ST_CL:   state_q <= ST_U22;
              default: state_q <= ST_U2XY;
            endcase
          end
        end
        ST_DEC: begin
          if (len_q < {16'd0, cfg_i.zero_length_limit}) begin
            state_q <= (cfg_i.show_zero || item_q.has_color || item_q.final_vector)
                       ? ST_ONE : ST_IDLE;
          end else begin
            state_q <= ST_BT;
          end
        end
        ST_BT: state_q <= ST_SH;
        ST_SH: begin
          if (idx_q == 3'd1) begin
            state_q <= heads ? ST_MW : ST_IDLE;
            idx_q   <= '0;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_MW: state_q <= ST_P1;
        ST_P1: begin
          if (idx_q == 3'd2) begin
            idx_q   <= '0;
            state_q <= (p_q[0] == '0 && p_q[1] == '0) ? ST_OFF : ST_QLD;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_QLD:  state_q <= ST_QPRE;
        ST_WLD:  state_q <= ST_WPRE;
        ST_QPRE: if (pre_done) state_q <= ST_QSQ;
        ST_WPRE: if (pre_done) state_q <= ST_WSQ;
        ST_QSQ, ST_WSQ, ST_U2XY: begin
          if (idx_q == 3'd1) begin
            idx_q <= '0;
            case (state_q)
              ST_QSQ:  state_q <= ST_R1;
              ST_WSQ:  state_q <= ST_R2;
              default: state_q <= ST_OFF;
            endcase
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_WSQ2: state_q <= ST_L1;
        ST_OFF, ST_HEAD: begin
          if (idx_q == 3'd5) begin
            idx_q   <= '0;
            state_q <= (state_q == ST_OFF) ? ST_HEAD : ST_IDLE;
          end else begin
            idx_q <= idx_q + 3'd1;
          end
        end
        ST_ONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_mark_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.prim_kind == KIND_MARK) |-> res_q.last && !res_q.prim_end)
    else $error("end marker must be the only word of its item");
  a_batch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.batch_done |-> res_q.last)
    else $error("batch_done without last");
  a_pick_shaft: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.pick_valid |-> (res_q.prim_kind == KIND_LINE) && !res_q.prim_end)
    else $error("pick tag off the shaft start");
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |=> !res_valid_q)
    else $error("word follows last with no gap");
`endif

endmodule

FILE: hdl/vector_arrow_glyph_generator_top.sv
`timescale 1ns / 1ps
// Top level of the vector arrow glyph generator: register file, intake queue, execution.
// Depends on vagg_pkg, vagg_front and vagg_back.
//
// Each accepted word (anchor plus vector, Q16.16) turns into up to eight vertex words on
// result_o, one per cycle within the shaft and within the arrowhead, each present for
// exactly one cycle while result_valid_o is high; the receiver cannot hold them off, so
// it must take every word as it appears. The block takes a new word on start whenever
// busy is low: a two-entry queue sits in front of the execution side, so the next word
// is taken while the current one is being worked. The execution side works one word at
// a time and takes the next from the queue only when it returns to idle. Its work is set
// by the shared one-bit-per-cycle square root unit, used once for the length and, for a
// shaft with arrowhead not along z, three more times for the wing directions, and by the
// shared one-bit-per-cycle divider, used four times in that case; a vector along z
// skips the wing-direction work. Write the configuration registers (APB, byte address
// 4 * index) only while the block is idle. Vertices saturate to the signed 32-bit range.
module vector_arrow_glyph_generator_top
  import vagg_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned INDEX_WIDTH = IndexWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start,
  input  item_t       item_i,
  output logic        busy,
  // result channel
  output logic        result_valid_o,
  output result_t     result_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q;
  logic  wr_en;
  logic  head_valid, pop;
  item_t head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file; write in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_factor      <= 32'sd65536;
      cfg_q.show_zero         <= 1'b0;
      cfg_q.anchor_mode       <= 2'd0;
      cfg_q.draw_head         <= 1'b1;
      cfg_q.head_length_frac  <= 17'd13107;
      cfg_q.head_width_frac   <= 17'd6554;
      cfg_q.pick_feedback     <= 1'b0;
      cfg_q.zero_length_limit <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_SCALE: cfg_q.scale_factor      <= $signed(pwdata);
        REG_SHOWZ: cfg_q.show_zero         <= pwdata[0];
        REG_ANCH:  cfg_q.anchor_mode       <= pwdata[1:0];
        REG_HEAD:  cfg_q.draw_head         <= pwdata[0];
        REG_HLEN:  cfg_q.head_length_frac  <= pwdata[16:0];
        REG_HWID:  cfg_q.head_width_frac   <= pwdata[16:0];
        REG_PICK:  cfg_q.pick_feedback     <= pwdata[0];
        REG_ZLIM:  cfg_q.zero_length_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      REG_SCALE: prdata = cfg_q.scale_factor;
      REG_SHOWZ: prdata = {31'd0, cfg_q.show_zero};
      REG_ANCH:  prdata = {30'd0, cfg_q.anchor_mode};
      REG_HEAD:  prdata = {31'd0, cfg_q.draw_head};
      REG_HLEN:  prdata = {15'd0, cfg_q.head_length_frac};
      REG_HWID:  prdata = {15'd0, cfg_q.head_width_frac};
      REG_PICK:  prdata = {31'd0, cfg_q.pick_feedback};
      REG_ZLIM:  prdata = {16'd0, cfg_q.zero_length_limit};
      default:   prdata = '0;
    endcase
  end

  vagg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .item_i       (item_i),
    .busy         (busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  vagg_back #(
    .FRAC_BITS   (FRAC_BITS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (head_valid),
    .item_i         (head),
    .item_pop_o     (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
